>>> src/acs_pkg.sv
// Package for the ADC offset calibration search: widths, codes and shared types.
// Used by scoped names in every design module of the block, not in acs_checker; depends on nothing.
package acs_pkg;

  // Low bits of the sample field that carry the conversion result.
  localparam int unsigned SampleBits = 16;
  localparam int unsigned SampleFieldBits = 16;
  // The window sum must hold 2047 full-scale samples.
  localparam int unsigned SumBits = 27;
  localparam int unsigned WinBits = 11;
  localparam int unsigned StepBits = 7;
  localparam int unsigned EstBits = 8;
  localparam int unsigned CodeBits = 7;
  localparam int unsigned KeptBits = 24;
  localparam int unsigned WordBits = 32;
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned OutDataBits = 40;

  localparam logic [WinBits-1:0] WindowReset = WinBits'(1000);
  localparam logic [StepBits-1:0] FirstStepReset = StepBits'(32);
  localparam logic [KeptBits-1:0] KeptReset = '0;

  typedef enum logic {
    KindStart  = 1'b0,
    KindSample = 1'b1
  } kind_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgWindow    = 2'd0,
    CfgFirstStep = 2'd1,
    CfgKept      = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [WinBits-1:0]  window_length;
    logic [StepBits-1:0] first_step;
    logic [KeptBits-1:0] kept_upper_bits;
  } cfg_t;

  typedef struct packed {
    kind_e                       kind;
    logic [SampleFieldBits-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic [WordBits-1:0] cal_word;
    logic [CodeBits-1:0] offset_code;
    logic                finished;
  } result_t;

endpackage

>>> src/acs_cfg_regs.sv
// Configuration registers of the offset calibration search.
// Depends on acs_pkg for the register indexes and the cfg_t type.
module acs_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [acs_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [acs_pkg::CfgDataBits-1:0]   cfg_data_i,
  output acs_pkg::cfg_t                     cfg_o
);

  acs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (acs_pkg::cfg_index_e'(cfg_index_i))
        acs_pkg::CfgWindow:    cfg_d.window_length = cfg_data_i[acs_pkg::WinBits-1:0];
        acs_pkg::CfgFirstStep: cfg_d.first_step = cfg_data_i[acs_pkg::StepBits-1:0];
        acs_pkg::CfgKept:      cfg_d.kept_upper_bits = cfg_data_i[acs_pkg::KeptBits-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length   <= acs_pkg::WindowReset;
      cfg_q.first_step      <= acs_pkg::FirstStepReset;
      cfg_q.kept_upper_bits <= acs_pkg::KeptReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/acs_in_reg.sv
// Input register of the offset calibration search: holds one item for the core.
// Depends on acs_pkg for the item_t type.
module acs_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  acs_pkg::item_t item_i,
  output logic           valid_o,
  output acs_pkg::item_t item_o,
  input  logic           advance_i
);

  logic           valid_q, valid_d;
  acs_pkg::item_t item_q;

  // A held item that moves on this cycle frees the register for the next one.
  assign ready_o = !valid_q || advance_i;
  assign valid_d = valid_i || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> src/acs_core.sv
// Search state and per-item update of the offset calibration search.
// Depends on acs_pkg for widths, the kind codes and the shared types.
module acs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  acs_pkg::item_t   item_i,
  input  acs_pkg::cfg_t    cfg_i,
  output logic             produce_o,
  output acs_pkg::result_t result_o
);

  logic signed [acs_pkg::SumBits-1:0] sum_q, sum_d, sum_inc;
  logic signed [acs_pkg::SumBits-1:0] sample_ext;
  logic [acs_pkg::WinBits-1:0]        seen_q, seen_d, seen_inc, limit;
  logic [acs_pkg::StepBits-1:0]       step_q, step_d, step_half;
  logic [acs_pkg::EstBits-1:0]        est_q, est_d;
  logic                               active_q, active_d;
  logic                               final_q, final_d;
  logic                               window_end;
  logic                               done;

  assign sample_ext = acs_pkg::SumBits'(signed'(item_i.sample[acs_pkg::SampleBits-1:0]));
  assign sum_inc    = sum_q + sample_ext;
  assign seen_inc   = seen_q + acs_pkg::WinBits'(1);
  // A window length of zero behaves as one.
  assign limit      = (cfg_i.window_length == '0) ? acs_pkg::WinBits'(1) : cfg_i.window_length;
  assign window_end = active_q && (seen_inc >= limit);
  assign step_half  = step_q >> 1;

  assign produce_o = (item_i.kind == acs_pkg::KindStart) || window_end;

  always_comb begin
    sum_d    = sum_q;
    seen_d   = seen_q;
    step_d   = step_q;
    est_d    = est_q;
    active_d = active_q;
    final_d  = final_q;
    done     = 1'b0;
    unique case (item_i.kind)
      acs_pkg::KindStart: begin
        sum_d    = '0;
        seen_d   = '0;
        step_d   = cfg_i.first_step;
        est_d    = '0;
        active_d = 1'b1;
        final_d  = (cfg_i.first_step == '0);
      end
      acs_pkg::KindSample: begin
        if (active_q) begin
          if (!window_end) begin
            sum_d  = sum_inc;
            seen_d = seen_inc;
          end else if (!final_q) begin
            est_d   = sum_inc[acs_pkg::SumBits-1] ? est_q - acs_pkg::EstBits'(step_q)
                                                   : est_q + acs_pkg::EstBits'(step_q);
            step_d  = step_half;
            final_d = (step_half == '0);
            sum_d   = '0;
            seen_d  = '0;
          end else begin
            // Final pass: only a negative sum moves the estimate, by one.
            if (sum_inc[acs_pkg::SumBits-1]) begin
              est_d = est_q - acs_pkg::EstBits'(1);
            end
            sum_d    = '0;
            seen_d   = '0;
            active_d = 1'b0;
            final_d  = 1'b0;
            done     = 1'b1;
          end
        end
      end
      default: sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      seen_q   <= '0;
      step_q   <= '0;
      est_q    <= '0;
      active_q <= 1'b0;
      final_q  <= 1'b0;
    end else if (fire_i) begin
      sum_q    <= sum_d;
      seen_q   <= seen_d;
      step_q   <= step_d;
      est_q    <= est_d;
      active_q <= active_d;
      final_q  <= final_d;
    end
  end

  assign result_o.offset_code = est_d[acs_pkg::CodeBits-1:0];
  assign result_o.cal_word    = {cfg_i.kept_upper_bits, 1'b0, est_d[acs_pkg::CodeBits-1:0]};
  assign result_o.finished    = done;

endmodule

>>> src/acs_out_reg.sv
// Output register of the offset calibration search: holds one result item.
// Depends on acs_pkg for the result_t type.
module acs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  acs_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output acs_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  acs_pkg::result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> src/adc_offset_calibration_search_top.sv
// Top level of the ADC offset calibration search (binary search on the offset code).
// Depends on acs_pkg and on acs_cfg_regs, acs_in_reg, acs_core and acs_out_reg.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind, tdata sample
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata cal_word, offset_code; tlast
//   cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled: an item is held in the input register,
// and the core updates the search state and loads the result register as the item leaves it.
// A result passes through the input register and then the result register before it is shown.
// A stalled output holds back only items that make a result; others keep flowing.
// Reset is asynchronous and clears all control state; the block then stands idle.
module adc_offset_calibration_search_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [acs_pkg::SampleFieldBits-1:0] s_axis_tdata,   // [15:0] sample
  input  logic                               s_axis_tuser,   // [0] kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [acs_pkg::OutDataBits-1:0]    m_axis_tdata,   // [31:0] cal_word,
                                                             // [38:32] offset_code, [39] zero
  output logic                               m_axis_tlast,   // finished
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [acs_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [acs_pkg::CfgDataBits-1:0]    cfg_data_i
);

  acs_pkg::cfg_t    cfg;
  acs_pkg::item_t   in_item, held_item;
  acs_pkg::result_t core_result, out_result;
  logic             held_valid, advance, produce, out_free;

  assign cfg_ready_o = 1'b1;

  acs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.kind   = acs_pkg::kind_e'(s_axis_tuser);
  assign in_item.sample = s_axis_tdata;

  acs_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .item_o    (held_item),
    .advance_i (advance)
  );

  assign advance = held_valid && (!produce || out_free);

  acs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (held_item),
    .cfg_i     (cfg),
    .produce_o (produce),
    .result_o  (core_result)
  );

  acs_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && produce),
    .result_i (core_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {1'b0, out_result.offset_code, out_result.cal_word};
  assign m_axis_tlast = out_result.finished;

endmodule

>>> src/acs_checker.sv
// Port-level checks for the ADC offset calibration search, bound to the top level.
// Depends on adc_offset_calibration_search_top for the bind target.
module acs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The code in the word and the separate code field come from the same estimate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == m_axis_tdata[38:32]))
    else $error("offset code differs from the low bits of the calibration word");

  // Bit 7 of the calibration word and the pad bit never carry data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0 && m_axis_tdata[39] == 1'b0))
    else $error("reserved bit set in output item");

  // A stalled result keeps its payload and its finished mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output item changed");

endmodule

bind adc_offset_calibration_search_top acs_checker u_acs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
